[hdl/tds_pkg.sv]
package tds_pkg;

    // Fixed field widths
    localparam int IDW         = 5;
    localparam int PCW         = 9;
    localparam int MAX_RESULTS = 32;
    localparam int NRW         = $clog2(MAX_RESULTS + 1);
    localparam int RBW         = $clog2(MAX_RESULTS);
    localparam logic [PCW-1:0] PEND_MAX = 9'd511;

    // Default sizes
    localparam int MAX_JOBS_DEF = 32;
    localparam int MAX_DEP_DEF  = 8;

    // Request kinds
    localparam logic [1:0] MODE_CREATE = 2'd0;
    localparam logic [1:0] MODE_ADD    = 2'd1;
    localparam logic [1:0] MODE_RUN    = 2'd2;
    localparam logic [1:0] MODE_DONE   = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_STARTED = 3'd1;
    localparam logic [2:0] ST_SELF    = 3'd2;
    localparam logic [2:0] ST_RANGE   = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;
    localparam logic [2:0] ST_CYCLIC  = 3'd5;
    localparam logic [2:0] ST_NOSTART = 3'd6;
    localparam logic [2:0] ST_UNDER   = 3'd7;

    // Datapath operations
    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_TAIL, OP_CREATE, OP_ADD_RD, OP_ADD_WR,
        OP_CP_INIT, OP_CP_RD, OP_CP_WR, OP_Q_RD, OP_Q_CUR, OP_RUN_START,
        OP_W_INIT, OP_DN, OP_L_RD, OP_L_CRD, OP_L_DEC, OP_UNDER, OP_C_END,
        OP_SC_RD, OP_SC_PUSH, OP_E_LOAD, OP_E_TAIL
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [2:0] stat;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       started;
        logic       jc_full;
        logic       self_dep;
        logic       job_oob;
        logic       pre_oob;
        logic       add_full;
        logic       idx_end;
        logic       q_empty;
        logic       visit_ok;
        logic       k_end;
        logic       d_oob;
        logic       cnt_zero;
        logic       kahn;
        logic       under;
        logic       nres_zero;
        logic       e_more;
        logic       ttail;
        logic       out_free;
    } dp_sts_t;

    // Controller states
    typedef enum logic [16:0] {
        S_IDLE   = 17'h00001,
        S_DEC    = 17'h00002,
        S_ADD    = 17'h00004,
        S_CP_RD  = 17'h00008,
        S_CP_WR  = 17'h00010,
        S_QCHK   = 17'h00020,
        S_QW     = 17'h00040,
        S_DN     = 17'h00080,
        S_LK     = 17'h00100,
        S_LID    = 17'h00200,
        S_LC     = 17'h00400,
        S_WEND   = 17'h00800,
        S_CFIN   = 17'h01000,
        S_SC_RD  = 17'h02000,
        S_SC_CHK = 17'h04000,
        S_EMIT   = 17'h08000,
        S_ERW    = 17'h10000
    } ctrl_state_t;

endpackage

[hdl/task_dependency_scheduler.sv]
// Task dependency scheduler.
// Input stream (s_): one request per item. s_tuser carries the request kind
// (create job, add dependency, run, job completed); s_tdata carries job_id
// and prerequisite_id. Result stream (m_): one or more items per request,
// the final one marked by m_tlast; m_tuser carries status and the ready flag,
// m_tdata the job number and the all-done flag.
// Requests are handled one at a time. Create writes the new job's counters;
// add dependency reads the counters, then writes them back with the new edge.
// Completion walks the dependent entries of the job, then drains the released
// jobs. Run copies the counters, walks every job taken from the internal ready
// queue and its edges, then scans for free jobs.
// Released jobs are staged in a 32-entry buffer and sent after the request's
// walk ends, so the all-done flag and the closing status are known.
// Reset clears the job count, unfinished count, started flag and output valid;
// the tables need no clearing pass. When the receiver stalls the output register
// holds the item and the drain waits; a new request is taken once the last result
// of the previous one sits in the output register.
module task_dependency_scheduler #(
    parameter int MAX_JOBS       = tds_pkg::MAX_JOBS_DEF,
    parameter int MAX_DEPENDENTS = tds_pkg::MAX_DEP_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // job_id[4:0], prerequisite_id[9:5], zeros
    input  logic [1:0]  s_tuser,   // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // job_id_res[4:0], all_done[5], zeros
    output logic [3:0]  m_tuser,   // status[2:0], ready_res[3]
    output logic        m_tlast
);

    tds_pkg::dp_cmd_t            cmd;
    tds_pkg::dp_sts_t            sts;
    logic [2:0]                  res_status;
    logic [tds_pkg::IDW-1:0]     res_job;
    logic                        res_rdy;
    logic                        res_done;

    tds_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    tds_datapath #(
        .MAX_JOBS       (MAX_JOBS),
        .MAX_DEPENDENTS (MAX_DEPENDENTS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_mode   (s_tuser),
        .s_job    (s_tdata[4:0]),
        .s_pre    (s_tdata[9:5]),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_status (res_status),
        .m_job    (res_job),
        .m_rdy    (res_rdy),
        .m_done   (res_done),
        .m_last   (m_tlast)
    );

    // Pack result fields
    assign m_tdata = {2'b00, res_done, res_job};
    assign m_tuser = {res_rdy, res_status};

endmodule

[hdl/tds_ram.sv]
module tds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/tds_datapath.sv]
module tds_datapath #(
    parameter int MAX_JOBS       = tds_pkg::MAX_JOBS_DEF,
    parameter int MAX_DEPENDENTS = tds_pkg::MAX_DEP_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  tds_pkg::dp_cmd_t         cmd,
    output tds_pkg::dp_sts_t         sts,
    input  logic [1:0]               s_mode,
    input  logic [tds_pkg::IDW-1:0]  s_job,
    input  logic [tds_pkg::IDW-1:0]  s_pre,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [2:0]               m_status,
    output logic [tds_pkg::IDW-1:0]  m_job,
    output logic                     m_rdy,
    output logic                     m_done,
    output logic                     m_last
);

    localparam int IDW  = tds_pkg::IDW;
    localparam int PCW  = tds_pkg::PCW;
    localparam int NRW  = tds_pkg::NRW;
    localparam int RBW  = tds_pkg::RBW;
    localparam int JW   = $clog2(MAX_JOBS);
    localparam int CW   = $clog2(MAX_JOBS + 1);
    localparam int DCW  = $clog2(MAX_DEPENDENTS + 1);
    localparam int DLW  = $clog2(MAX_JOBS * MAX_DEPENDENTS);
    localparam int CMPW = (CW > IDW) ? CW : IDW;

    // Job state
    logic [1:0]     mode_reg, mode_next;
    logic [IDW-1:0] job_reg, job_next, pre_reg, pre_next;
    logic [CW-1:0]  jc_reg, jc_next, unfin_reg, unfin_next;
    logic           started_reg, started_next;
    // Walk state
    logic [CW-1:0]  idx_reg, idx_next, head_reg, head_next, tail_reg, tail_next;
    logic [CW-1:0]  vis_reg, vis_next;
    logic [JW-1:0]  cur_reg, cur_next, d_reg, d_next;
    logic [DCW-1:0] dn_reg, dn_next, k_reg, k_next;
    logic           kahn_reg, kahn_next, under_reg, under_next;
    // Result staging
    logic [NRW-1:0] nres_reg, nres_next, eidx_reg, eidx_next, nemit;
    logic           ttail_reg, ttail_next;
    logic [2:0]     tstat_reg, tstat_next;
    logic [IDW-1:0] tid_reg, tid_next;
    // Output register
    logic           mv_reg, mv_next, mrdy_reg, mrdy_next, mdone_reg, mdone_next;
    logic           mlast_reg, mlast_next;
    logic [2:0]     mstat_reg, mstat_next;
    logic [IDW-1:0] mjob_reg, mjob_next;

    // Memory ports
    logic           pend_we, dcnt_we, dl_we, scr_we, rq_we, rb_we;
    logic [JW-1:0]  pend_wa, pend_ra, dcnt_wa, dcnt_ra, scr_wa, scr_ra, rq_wa, rq_ra;
    logic [DLW-1:0] dl_wa, dl_ra;
    logic [RBW-1:0] rb_wa;
    logic [PCW-1:0] pend_wd, pend_rd, scr_wd, scr_rd, cnt;
    logic [DCW-1:0] dcnt_wd, dcnt_rd;
    logic [JW-1:0]  dl_wd, dl_rd, rq_wd, rq_rd;
    logic [IDW-1:0] rb_wd, rb_rd;

    tds_ram #(.WIDTH(PCW), .DEPTH(MAX_JOBS)) u_pend (
        .aclk(aclk), .we(pend_we), .waddr(pend_wa), .wdata(pend_wd),
        .raddr(pend_ra), .rdata(pend_rd));
    tds_ram #(.WIDTH(DCW), .DEPTH(MAX_JOBS)) u_dcnt (
        .aclk(aclk), .we(dcnt_we), .waddr(dcnt_wa), .wdata(dcnt_wd),
        .raddr(dcnt_ra), .rdata(dcnt_rd));
    tds_ram #(.WIDTH(JW), .DEPTH(MAX_JOBS * MAX_DEPENDENTS)) u_dlist (
        .aclk(aclk), .we(dl_we), .waddr(dl_wa), .wdata(dl_wd),
        .raddr(dl_ra), .rdata(dl_rd));
    tds_ram #(.WIDTH(PCW), .DEPTH(MAX_JOBS)) u_scr (
        .aclk(aclk), .we(scr_we), .waddr(scr_wa), .wdata(scr_wd),
        .raddr(scr_ra), .rdata(scr_rd));
    tds_ram #(.WIDTH(JW), .DEPTH(MAX_JOBS)) u_rq (
        .aclk(aclk), .we(rq_we), .waddr(rq_wa), .wdata(rq_wd),
        .raddr(rq_ra), .rdata(rq_rd));
    tds_ram #(.WIDTH(IDW), .DEPTH(tds_pkg::MAX_RESULTS)) u_rbuf (
        .aclk(aclk), .we(rb_we), .waddr(rb_wa), .wdata(rb_wd),
        .raddr(eidx_reg[RBW-1:0]), .rdata(rb_rd));

    // Counter under test during a walk
    assign cnt = kahn_reg ? scr_rd : pend_rd;

    // Ready items to emit; a closing underflow item takes the final slot
    assign nemit = (ttail_reg && nres_reg == NRW'(tds_pkg::MAX_RESULTS)) ?
                   NRW'(tds_pkg::MAX_RESULTS - 1) : nres_reg;

    // Status toward the controller
    always_comb begin
        sts.mode      = mode_reg;
        sts.started   = started_reg;
        sts.jc_full   = (jc_reg == CW'(MAX_JOBS));
        sts.self_dep  = (job_reg == pre_reg);
        sts.job_oob   = (CMPW'(job_reg) >= CMPW'(jc_reg));
        sts.pre_oob   = (CMPW'(pre_reg) >= CMPW'(jc_reg));
        sts.add_full  = (dcnt_rd >= DCW'(MAX_DEPENDENTS)) || (pend_rd == tds_pkg::PEND_MAX);
        sts.idx_end   = (idx_reg == jc_reg);
        sts.q_empty   = (head_reg == tail_reg);
        sts.visit_ok  = (vis_reg == jc_reg);
        sts.k_end     = (k_reg == dn_reg);
        sts.d_oob     = (CW'(dl_rd) >= jc_reg);
        sts.cnt_zero  = (cnt == '0);
        sts.kahn      = kahn_reg;
        sts.under     = under_reg;
        sts.nres_zero = (nres_reg == '0);
        sts.e_more    = (eidx_reg < nemit);
        sts.ttail     = ttail_reg;
        sts.out_free  = !mv_reg || m_ready;
    end

    // Next-state and memory control per operation
    always_comb begin
        mode_next = mode_reg;   job_next = job_reg;     pre_next = pre_reg;
        jc_next = jc_reg;       unfin_next = unfin_reg; started_next = started_reg;
        idx_next = idx_reg;     head_next = head_reg;   tail_next = tail_reg;
        vis_next = vis_reg;     cur_next = cur_reg;     d_next = d_reg;
        dn_next = dn_reg;       k_next = k_reg;         kahn_next = kahn_reg;
        under_next = under_reg; nres_next = nres_reg;   eidx_next = eidx_reg;
        ttail_next = ttail_reg; tstat_next = tstat_reg; tid_next = tid_reg;
        mv_next = mv_reg && !m_ready;
        mrdy_next = mrdy_reg;   mdone_next = mdone_reg; mlast_next = mlast_reg;
        mstat_next = mstat_reg; mjob_next = mjob_reg;

        pend_we = 1'b0; pend_wa = JW'(job_reg); pend_wd = '0; pend_ra = JW'(idx_reg);
        dcnt_we = 1'b0; dcnt_wa = JW'(pre_reg); dcnt_wd = '0; dcnt_ra = JW'(pre_reg);
        dl_we = 1'b0;
        dl_wa = DLW'(JW'(pre_reg)) * DLW'(MAX_DEPENDENTS) + DLW'(dcnt_rd);
        dl_wd = JW'(job_reg);
        dl_ra = DLW'(cur_reg) * DLW'(MAX_DEPENDENTS) + DLW'(k_reg);
        scr_we = 1'b0; scr_wa = d_reg; scr_wd = cnt - PCW'(1); scr_ra = dl_rd;
        rq_we = 1'b0; rq_wa = JW'(tail_reg); rq_wd = d_reg; rq_ra = JW'(head_reg);
        rb_we = 1'b0; rb_wa = nres_reg[RBW-1:0]; rb_wd = IDW'(d_reg);

        case (cmd.op)
            tds_pkg::OP_LOAD: begin
                mode_next = s_mode; job_next = s_job; pre_next = s_pre;
                nres_next = '0; under_next = 1'b0; ttail_next = 1'b0; eidx_next = '0;
            end
            tds_pkg::OP_TAIL: begin
                ttail_next = 1'b1; tstat_next = cmd.stat; tid_next = '0;
            end
            tds_pkg::OP_CREATE: begin
                pend_we = 1'b1; pend_wa = JW'(jc_reg); pend_wd = '0;
                dcnt_we = 1'b1; dcnt_wa = JW'(jc_reg); dcnt_wd = '0;
                ttail_next = 1'b1; tstat_next = tds_pkg::ST_OK; tid_next = IDW'(jc_reg);
                jc_next = jc_reg + CW'(1);
            end
            tds_pkg::OP_ADD_RD: begin
                pend_ra = JW'(job_reg); dcnt_ra = JW'(pre_reg);
            end
            tds_pkg::OP_ADD_WR: begin
                pend_we = 1'b1; pend_wa = JW'(job_reg); pend_wd = pend_rd + PCW'(1);
                dl_we = 1'b1;
                dcnt_we = 1'b1; dcnt_wa = JW'(pre_reg); dcnt_wd = dcnt_rd + DCW'(1);
                ttail_next = 1'b1; tstat_next = tds_pkg::ST_OK; tid_next = '0;
            end
            tds_pkg::OP_CP_INIT: begin
                idx_next = '0; head_next = '0; tail_next = '0; vis_next = '0;
            end
            tds_pkg::OP_CP_RD: begin
                pend_ra = JW'(idx_reg);
            end
            tds_pkg::OP_CP_WR: begin
                scr_we = 1'b1; scr_wa = JW'(idx_reg); scr_wd = pend_rd;
                if (pend_rd == '0) begin
                    rq_we = 1'b1; rq_wd = JW'(idx_reg);
                    tail_next = tail_reg + CW'(1);
                end
                idx_next = idx_reg + CW'(1);
            end
            tds_pkg::OP_Q_RD: begin
                rq_ra = JW'(head_reg);
                head_next = head_reg + CW'(1);
                vis_next = vis_reg + CW'(1);
            end
            tds_pkg::OP_Q_CUR: begin
                cur_next = rq_rd; dcnt_ra = rq_rd; kahn_next = 1'b1;
            end
            tds_pkg::OP_W_INIT: begin
                cur_next = JW'(job_reg); dcnt_ra = JW'(job_reg); kahn_next = 1'b0;
            end
            tds_pkg::OP_DN: begin
                dn_next = dcnt_rd; k_next = '0;
            end
            tds_pkg::OP_L_CRD: begin
                d_next = dl_rd; scr_ra = dl_rd; pend_ra = dl_rd;
            end
            tds_pkg::OP_L_DEC: begin
                if (kahn_reg) begin
                    scr_we = 1'b1;
                end else begin
                    pend_we = 1'b1; pend_wa = d_reg; pend_wd = cnt - PCW'(1);
                end
                if (cnt == PCW'(1)) begin
                    if (kahn_reg) begin
                        rq_we = 1'b1;
                        tail_next = tail_reg + CW'(1);
                    end else if (nres_reg < NRW'(tds_pkg::MAX_RESULTS)) begin
                        rb_we = 1'b1;
                        nres_next = nres_reg + NRW'(1);
                    end
                end
                k_next = k_reg + DCW'(1);
            end
            tds_pkg::OP_UNDER: begin
                under_next = 1'b1;
            end
            tds_pkg::OP_C_END: begin
                if (!under_reg) begin
                    if (unfin_reg == '0) begin
                        under_next = 1'b1;
                    end else begin
                        unfin_next = unfin_reg - CW'(1);
                    end
                end
            end
            tds_pkg::OP_RUN_START: begin
                started_next = 1'b1; unfin_next = jc_reg; idx_next = '0;
            end
            tds_pkg::OP_SC_RD: begin
                pend_ra = JW'(idx_reg);
            end
            tds_pkg::OP_SC_PUSH: begin
                if (pend_rd == '0 && nres_reg < NRW'(tds_pkg::MAX_RESULTS)) begin
                    rb_we = 1'b1; rb_wd = IDW'(idx_reg);
                    nres_next = nres_reg + NRW'(1);
                end
                idx_next = idx_reg + CW'(1);
            end
            tds_pkg::OP_E_LOAD: begin
                mv_next = 1'b1; mstat_next = tds_pkg::ST_OK; mjob_next = rb_rd;
                mrdy_next = 1'b1;
                mdone_next = started_reg && (unfin_reg == '0);
                mlast_next = (eidx_reg + NRW'(1) == nemit) && !ttail_reg;
                eidx_next = eidx_reg + NRW'(1);
            end
            tds_pkg::OP_E_TAIL: begin
                mv_next = 1'b1; mstat_next = tstat_reg; mjob_next = tid_reg;
                mrdy_next = 1'b0;
                mdone_next = started_reg && (unfin_reg == '0);
                mlast_next = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            jc_reg      <= '0;
            unfin_reg   <= '0;
            started_reg <= 1'b0;
            mv_reg      <= 1'b0;
        end else begin
            jc_reg      <= jc_next;
            unfin_reg   <= unfin_next;
            started_reg <= started_next;
            mv_reg      <= mv_next;
        end
    end

    // Payload and walk registers
    always_ff @(posedge aclk) begin
        mode_reg <= mode_next;   job_reg <= job_next;     pre_reg <= pre_next;
        idx_reg <= idx_next;     head_reg <= head_next;   tail_reg <= tail_next;
        vis_reg <= vis_next;     cur_reg <= cur_next;     d_reg <= d_next;
        dn_reg <= dn_next;       k_reg <= k_next;         kahn_reg <= kahn_next;
        under_reg <= under_next; nres_reg <= nres_next;   eidx_reg <= eidx_next;
        ttail_reg <= ttail_next; tstat_reg <= tstat_next; tid_reg <= tid_next;
        mrdy_reg <= mrdy_next;   mdone_reg <= mdone_next; mlast_reg <= mlast_next;
        mstat_reg <= mstat_next; mjob_reg <= mjob_next;
    end

    assign m_valid  = mv_reg;
    assign m_status = mstat_reg;
    assign m_job    = mjob_reg;
    assign m_rdy    = mrdy_reg;
    assign m_done   = mdone_reg;
    assign m_last   = mlast_reg;

endmodule

[hdl/tds_ctrl.sv]
module tds_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    output tds_pkg::dp_cmd_t cmd,
    input  tds_pkg::dp_sts_t sts
);

    tds_pkg::ctrl_state_t state_reg, state_next;

    assign in_ready = (state_reg == tds_pkg::S_IDLE);

    // Sequence the datapath
    always_comb begin
        state_next = state_reg;
        cmd.op     = tds_pkg::OP_NONE;
        cmd.stat   = tds_pkg::ST_OK;
        case (state_reg)
            tds_pkg::S_IDLE: begin
                if (in_valid) begin
                    cmd.op = tds_pkg::OP_LOAD;
                    state_next = tds_pkg::S_DEC;
                end
            end
            tds_pkg::S_DEC: begin
                state_next = tds_pkg::S_EMIT;
                cmd.op = tds_pkg::OP_TAIL;
                case (sts.mode)
                    tds_pkg::MODE_CREATE: begin
                        if (sts.started) cmd.stat = tds_pkg::ST_STARTED;
                        else if (sts.jc_full) cmd.stat = tds_pkg::ST_FULL;
                        else cmd.op = tds_pkg::OP_CREATE;
                    end
                    tds_pkg::MODE_ADD: begin
                        if (sts.started) cmd.stat = tds_pkg::ST_STARTED;
                        else if (sts.self_dep) cmd.stat = tds_pkg::ST_SELF;
                        else if (sts.job_oob || sts.pre_oob) cmd.stat = tds_pkg::ST_RANGE;
                        else begin
                            cmd.op = tds_pkg::OP_ADD_RD;
                            state_next = tds_pkg::S_ADD;
                        end
                    end
                    tds_pkg::MODE_RUN: begin
                        if (sts.started) cmd.stat = tds_pkg::ST_STARTED;
                        else begin
                            cmd.op = tds_pkg::OP_CP_INIT;
                            state_next = tds_pkg::S_CP_RD;
                        end
                    end
                    default: begin
                        if (!sts.started) cmd.stat = tds_pkg::ST_NOSTART;
                        else if (sts.job_oob) cmd.stat = tds_pkg::ST_RANGE;
                        else begin
                            cmd.op = tds_pkg::OP_W_INIT;
                            state_next = tds_pkg::S_DN;
                        end
                    end
                endcase
            end
            tds_pkg::S_ADD: begin
                if (sts.add_full) begin
                    cmd.op = tds_pkg::OP_TAIL;
                    cmd.stat = tds_pkg::ST_FULL;
                end else begin
                    cmd.op = tds_pkg::OP_ADD_WR;
                end
                state_next = tds_pkg::S_EMIT;
            end
            // Copy counters into scratch and seed the queue
            tds_pkg::S_CP_RD: begin
                if (sts.idx_end) begin
                    state_next = tds_pkg::S_QCHK;
                end else begin
                    cmd.op = tds_pkg::OP_CP_RD;
                    state_next = tds_pkg::S_CP_WR;
                end
            end
            tds_pkg::S_CP_WR: begin
                cmd.op = tds_pkg::OP_CP_WR;
                state_next = tds_pkg::S_CP_RD;
            end
            tds_pkg::S_QCHK: begin
                if (!sts.q_empty) begin
                    cmd.op = tds_pkg::OP_Q_RD;
                    state_next = tds_pkg::S_QW;
                end else if (sts.visit_ok) begin
                    cmd.op = tds_pkg::OP_RUN_START;
                    state_next = tds_pkg::S_SC_RD;
                end else begin
                    cmd.op = tds_pkg::OP_TAIL;
                    cmd.stat = tds_pkg::ST_CYCLIC;
                    state_next = tds_pkg::S_EMIT;
                end
            end
            tds_pkg::S_QW: begin
                cmd.op = tds_pkg::OP_Q_CUR;
                state_next = tds_pkg::S_DN;
            end
            // Walk the dependents of one job
            tds_pkg::S_DN: begin
                cmd.op = tds_pkg::OP_DN;
                state_next = tds_pkg::S_LK;
            end
            tds_pkg::S_LK: begin
                if (sts.k_end) begin
                    state_next = tds_pkg::S_WEND;
                end else begin
                    cmd.op = tds_pkg::OP_L_RD;
                    state_next = tds_pkg::S_LID;
                end
            end
            tds_pkg::S_LID: begin
                if (sts.d_oob) begin
                    cmd.op = tds_pkg::OP_UNDER;
                    state_next = tds_pkg::S_WEND;
                end else begin
                    cmd.op = tds_pkg::OP_L_CRD;
                    state_next = tds_pkg::S_LC;
                end
            end
            tds_pkg::S_LC: begin
                if (sts.cnt_zero) begin
                    cmd.op = tds_pkg::OP_UNDER;
                    state_next = tds_pkg::S_WEND;
                end else begin
                    cmd.op = tds_pkg::OP_L_DEC;
                    state_next = tds_pkg::S_LK;
                end
            end
            tds_pkg::S_WEND: begin
                if (sts.kahn) begin
                    if (sts.under) begin
                        cmd.op = tds_pkg::OP_TAIL;
                        cmd.stat = tds_pkg::ST_UNDER;
                        state_next = tds_pkg::S_EMIT;
                    end else begin
                        state_next = tds_pkg::S_QCHK;
                    end
                end else begin
                    cmd.op = tds_pkg::OP_C_END;
                    state_next = tds_pkg::S_CFIN;
                end
            end
            tds_pkg::S_CFIN: begin
                if (sts.under) begin
                    cmd.op = tds_pkg::OP_TAIL;
                    cmd.stat = tds_pkg::ST_UNDER;
                end else if (sts.nres_zero) begin
                    cmd.op = tds_pkg::OP_TAIL;
                end
                state_next = tds_pkg::S_EMIT;
            end
            // Release every job with nothing pending
            tds_pkg::S_SC_RD: begin
                if (sts.idx_end) begin
                    state_next = tds_pkg::S_CFIN;
                end else begin
                    cmd.op = tds_pkg::OP_SC_RD;
                    state_next = tds_pkg::S_SC_CHK;
                end
            end
            tds_pkg::S_SC_CHK: begin
                cmd.op = tds_pkg::OP_SC_PUSH;
                state_next = tds_pkg::S_SC_RD;
            end
            // Drain staged results
            tds_pkg::S_EMIT: begin
                if (sts.e_more) begin
                    state_next = tds_pkg::S_ERW;
                end else if (!sts.ttail) begin
                    state_next = tds_pkg::S_IDLE;
                end else if (sts.out_free) begin
                    cmd.op = tds_pkg::OP_E_TAIL;
                    state_next = tds_pkg::S_IDLE;
                end
            end
            tds_pkg::S_ERW: begin
                if (sts.out_free) begin
                    cmd.op = tds_pkg::OP_E_LOAD;
                    state_next = tds_pkg::S_EMIT;
                end
            end
            default: begin
                state_next = tds_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tds_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[bench/testbench.sv]
module testbench;

    localparam int JOBS  = 32;
    localparam int DEPS  = 8;
    localparam int LIMIT = 600000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [2:0] status;
        logic [4:0] job;
        logic       ready;
        logic       all_done;
        logic       last;
    } result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [1:0]  s_tuser = tds_pkg::MODE_CREATE;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    // scheduler state as predicted
    logic [5:0]  job_total;
    logic        sched_started;
    logic [5:0]  jobs_open;
    logic [8:0]  wait_count [JOBS];
    logic [3:0]  succ_count [JOBS];
    logic [4:0]  succ_list  [JOBS*DEPS];

    result_t     step_items[$];
    result_t     expected_items[$];
    int          released_jobs[$];

    int          cycle = 0;
    int          errors = 0;
    int          requests = 0;
    int          results_seen = 0;
    bit          idle_on = 1'b1;
    bit          holding = 1'b0;
    event        hold_start;

    task_dependency_scheduler DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always #2 aclk = ~aclk;

    // count cycles and stop a hung run
    always @(posedge aclk) begin
        cycle <= cycle + 1;
        if (cycle > LIMIT) begin
            $display("timeout after %0d cycles", cycle);
            $display("[task_dependency_scheduler] ERROR");
            $finish;
        end
    end

    // count out one long receiver hold
    always begin
        @(hold_start);
        holding = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        holding = 1'b0;
    end

    // receiver: long hold when asked, random stalls while idle_on is set, else always ready
    always @(posedge aclk) begin
        if (holding)
            m_tready <= 1'b0;
        else if (idle_on)
            m_tready <= ($urandom_range(99) >= 11);
        else
            m_tready <= 1'b1;
    end

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycle);
        errors++;
    endtask

    // compare each result with the oldest expectation
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_items.size() == 0) begin
                report("unexpected result, status", m_tuser[2:0], -1);
            end else begin
                want = expected_items[0];
                expected_items.delete(0);
                if (m_tuser[2:0] != want.status) report("status", m_tuser[2:0], want.status);
                if (m_tdata[4:0] != want.job)    report("job", m_tdata[4:0], want.job);
                if (m_tuser[3] != want.ready)    report("ready", m_tuser[3], want.ready);
                if (m_tdata[5] != want.all_done) report("all_done", m_tdata[5], want.all_done);
                if (m_tlast != want.last)        report("last", m_tlast, want.last);
            end
        end
    end

    function automatic void emit(logic [2:0] st, logic [4:0] id, logic rdy);
        result_t r;
        if (step_items.size() >= tds_pkg::MAX_RESULTS) return;
        r = '{st, id, rdy, 1'b0, 1'b0};
        step_items.insert(step_items.size(), r);
    endfunction

    // Kahn's method over a scratch copy of the wait counters
    function automatic logic [2:0] cycle_check();
        logic [8:0] indeg [JOBS];
        int order [$];
        int cur, d, seen;
        seen = 0;
        for (int i = 0; i < job_total; i++) begin
            indeg[i] = wait_count[i];
            if (indeg[i] == 0) order.insert(order.size(), i);
        end
        while (order.size() > 0) begin
            cur = order[0];
            order.delete(0);
            seen++;
            for (int k = 0; k < succ_count[cur]; k++) begin
                d = succ_list[cur*DEPS + k];
                if (d >= job_total || indeg[d] == 0) return tds_pkg::ST_UNDER;
                indeg[d]--;
                if (indeg[d] == 0) order.insert(order.size(), d);
            end
        end
        return (seen == job_total) ? tds_pkg::ST_OK : tds_pkg::ST_CYCLIC;
    endfunction

    // work out the results of one accepted request and advance the state
    function automatic void schedule_predict(logic [1:0] mode, logic [4:0] job,
                                             logic [4:0] pre);
        logic [2:0] chk;
        logic under;
        int d;
        step_items.delete();
        case (mode)
            tds_pkg::MODE_CREATE: begin
                if (sched_started) emit(tds_pkg::ST_STARTED, 5'd0, 1'b0);
                else if (job_total >= JOBS) emit(tds_pkg::ST_FULL, 5'd0, 1'b0);
                else begin
                    wait_count[job_total] = '0;
                    succ_count[job_total] = '0;
                    emit(tds_pkg::ST_OK, job_total[4:0], 1'b0);
                    job_total++;
                end
            end
            tds_pkg::MODE_ADD: begin
                if (sched_started) emit(tds_pkg::ST_STARTED, 5'd0, 1'b0);
                else if (job == pre) emit(tds_pkg::ST_SELF, 5'd0, 1'b0);
                else if (job >= job_total || pre >= job_total)
                    emit(tds_pkg::ST_RANGE, 5'd0, 1'b0);
                else if (succ_count[pre] >= DEPS || wait_count[job] >= tds_pkg::PEND_MAX)
                    emit(tds_pkg::ST_FULL, 5'd0, 1'b0);
                else begin
                    wait_count[job]++;
                    succ_list[pre*DEPS + succ_count[pre]] = job;
                    succ_count[pre]++;
                    emit(tds_pkg::ST_OK, 5'd0, 1'b0);
                end
            end
            tds_pkg::MODE_RUN: begin
                if (sched_started) emit(tds_pkg::ST_STARTED, 5'd0, 1'b0);
                else begin
                    chk = cycle_check();
                    if (chk != tds_pkg::ST_OK) emit(chk, 5'd0, 1'b0);
                    else begin
                        sched_started = 1'b1;
                        jobs_open = job_total;
                        for (int i = 0; i < job_total; i++)
                            if (wait_count[i] == 0) begin
                                emit(tds_pkg::ST_OK, 5'(i), 1'b1);
                                released_jobs.insert(released_jobs.size(), i);
                            end
                        if (step_items.size() == 0) emit(tds_pkg::ST_OK, 5'd0, 1'b0);
                    end
                end
            end
            default: begin
                if (!sched_started) emit(tds_pkg::ST_NOSTART, 5'd0, 1'b0);
                else if (job >= job_total) emit(tds_pkg::ST_RANGE, 5'd0, 1'b0);
                else begin
                    under = 1'b0;
                    for (int k = 0; k < succ_count[job]; k++) begin
                        d = succ_list[job*DEPS + k];
                        if (d >= job_total || wait_count[d] == 0) begin
                            under = 1'b1;
                            break;
                        end
                        wait_count[d]--;
                        if (wait_count[d] == 0) begin
                            emit(tds_pkg::ST_OK, 5'(d), 1'b1);
                            released_jobs.insert(released_jobs.size(), d);
                        end
                    end
                    if (!under) begin
                        if (jobs_open == 0) under = 1'b1;
                        else jobs_open--;
                    end
                    if (under) begin
                        // the closing underflow item always gets the final slot
                        if (step_items.size() >= tds_pkg::MAX_RESULTS)
                            step_items.delete(step_items.size() - 1);
                        emit(tds_pkg::ST_UNDER, 5'd0, 1'b0);
                    end else if (step_items.size() == 0) emit(tds_pkg::ST_OK, 5'd0, 1'b0);
                end
            end
        endcase
        foreach (step_items[i]) begin
            step_items[i].all_done = sched_started && jobs_open == 0;
            step_items[i].last = (i == step_items.size() - 1);
            expected_items.insert(expected_items.size(), step_items[i]);
        end
    endfunction

    // offer one request and hold it until accepted
    task automatic send_request(logic [1:0] mode, logic [4:0] job, logic [4:0] pre);
        if (idle_on && $urandom_range(99) < 11) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {6'd0, pre, job};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        schedule_predict(mode, job, pre);
        requests++;
    endtask

    // drop valid and wait for every outstanding result
    task automatic wait_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_items.size() > 0) @(posedge aclk);
    endtask

    task automatic test_before_start();
        idle_on = 1'b0;
        send_request(tds_pkg::MODE_DONE, 5'd31, 5'd31);
        send_request(tds_pkg::MODE_ADD, 5'd0, 5'd0);
        send_request(tds_pkg::MODE_ADD, 5'd1, 5'd0);
        send_request(tds_pkg::MODE_CREATE, 5'd31, 5'd31);
        send_request(tds_pkg::MODE_CREATE, 5'd0, 5'd0);
        send_request(tds_pkg::MODE_ADD, 5'd31, 5'd1);
        send_request(tds_pkg::MODE_ADD, 5'd1, 5'd31);
        send_request(tds_pkg::MODE_ADD, 5'd1, 5'd0);
    endtask

    task automatic test_fill_tables();
        while (job_total < JOBS)
            send_request(tds_pkg::MODE_CREATE, 5'($urandom_range(31)), 5'($urandom_range(31)));
        send_request(tds_pkg::MODE_CREATE, 5'd0, 5'd0);
        // fill the successor list of job 0, then one past it
        for (int j = 2; j <= 9; j++)
            send_request(tds_pkg::MODE_ADD, 5'(j), 5'd0);
        send_request(tds_pkg::MODE_ADD, 5'd10, 5'd0);
        send_request(tds_pkg::MODE_ADD, 5'd31, 5'd31);
        idle_on = 1'b1;
    endtask

    task automatic test_random_edges();
        int p, j;
        repeat (45) begin
            if ($urandom_range(99) < 10) begin
                j = $urandom_range(31);
                send_request(tds_pkg::MODE_ADD, 5'(j), 5'(j));
            end else begin
                p = $urandom_range(30);
                j = $urandom_range(p + 1, 31);
                send_request(tds_pkg::MODE_ADD, 5'(j), 5'(p));
            end
        end
        wait_results();
    endtask

    task automatic test_run_and_after();
        send_request(tds_pkg::MODE_RUN, 5'($urandom_range(31)), 5'($urandom_range(31)));
        send_request(tds_pkg::MODE_CREATE, 5'd0, 5'd0);
        send_request(tds_pkg::MODE_ADD, 5'd3, 5'd1);
        send_request(tds_pkg::MODE_RUN, 5'd0, 5'd0);
        wait_results();
    endtask

    task automatic test_completions();
        int pick, n;
        n = 0;
        while (released_jobs.size() > 0 && n < 200) begin
            if (n == 12) begin
                // long receiver hold while requests keep coming
                -> hold_start;
            end
            if (n == 24) wait_results();
            if ($urandom_range(99) < 15) begin
                send_request(tds_pkg::MODE_DONE, 5'($urandom_range(31)),
                             5'($urandom_range(31)));
            end else begin
                pick = $urandom_range(released_jobs.size() - 1);
                send_request(tds_pkg::MODE_DONE, 5'(released_jobs[pick]),
                             5'($urandom_range(31)));
                released_jobs.delete(pick);
            end
            n++;
        end
        // everything is finished: further completions underflow
        send_request(tds_pkg::MODE_DONE, 5'd0, 5'd0);
        send_request(tds_pkg::MODE_DONE, 5'd31, 5'd0);
        wait_results();
    endtask

    initial begin
        job_total = '0;
        sched_started = 1'b0;
        jobs_open = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_before_start();
        test_fill_tables();
        test_random_edges();
        test_run_and_after();
        test_completions();
        repeat (100) @(posedge aclk);
        $display("covered %0d requests and %0d results: errors before start, table and list",
                 requests, results_seen);
        $display("full, random acyclic graph, run, completions in random order, underflow");
        if (errors == 0)
            $display("[task_dependency_scheduler] OK");
        else
            $display("[task_dependency_scheduler] ERROR");
        $finish;
    end

endmodule

[sim.f]
hdl/tds_pkg.sv
hdl/tds_ram.sv
hdl/tds_datapath.sv
hdl/tds_ctrl.sv
hdl/task_dependency_scheduler.sv
bench/testbench.sv
